[src/a2a_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2a_pkg
// Shared constants, side-band type and Q30 helpers for the atan2 block.
// ----------------------------------------------------------------------------
package a2a_pkg;

   localparam int FRAC_BITS               = 30;
   localparam int DEF_SAMPLE_WIDTH        = 16;
   localparam int DEF_ANGLE_FRAC_BITS     = 13;
   localparam int ANGLE_WIDTH             = 16;
   localparam int MODE_WIDTH              = 3;

   localparam logic [MODE_WIDTH-1:0] MODE_RAT0 = 3'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_RAT1 = 3'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_QUAD0 = 3'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_QUAD1 = 3'd3;
   localparam logic [MODE_WIDTH-1:0] MODE_CUB = 3'd4;
   localparam logic [MODE_WIDTH-1:0] MODE_MIX = 3'd5;

   localparam logic [31:0] ONE_Q30        = 32'd1073741824;
   localparam logic [63:0] HALF_Q30       = 64'd536870912;
   localparam logic [33:0] PI_Q30         = 34'd3373259426;
   localparam logic [33:0] HALF_PI_Q30    = 34'd1686629713;
   localparam logic [31:0] QUARTER_PI_Q30 = 32'd843314857;
   localparam logic [31:0] K_RAT0         = 32'd301989888;
   localparam logic [31:0] K_RAT1         = 32'd301571129;
   localparam logic [31:0] K_QUAD0        = 32'd306016420;
   localparam logic [31:0] K_QUAD1        = 32'd293131518;
   localparam logic [31:0] K_CUB1         = 32'd200770394;
   localparam logic [31:0] K_CUB3         = 32'd206096153;
   localparam logic [31:0] K_MIX0         = 32'd262744624;
   localparam logic [31:0] K_MIX1         = 32'd71189083;
   localparam logic [34:0] OUT_MAX        = 35'd32767;

   typedef struct packed {
      logic zero;
      logic swap;
      logic xneg;
      logic i_pos;
      logic q_nonneg;
      logic q_pos;
   } side_type;

   function automatic logic [31:0] qmul(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] p;
      p = 64'(a) * 64'(b) + HALF_Q30;
      return p[61:30];
   endfunction

   function automatic logic is_rational(input logic [MODE_WIDTH-1:0] m);
      return !(m == MODE_QUAD0 || m == MODE_QUAD1 || m == MODE_CUB || m == MODE_MIX);
   endfunction

endpackage

[src/a2a_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2a_if
// Valid/ready channels for sample pairs and angle results.
// ----------------------------------------------------------------------------
interface a2a_req_if #(parameter int SAMPLE_WIDTH = a2a_pkg::DEF_SAMPLE_WIDTH);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] in_phase;
   logic signed [SAMPLE_WIDTH-1:0] quadrature;
   modport source (output valid, output in_phase, output quadrature, input ready);
   modport sink (input valid, input in_phase, input quadrature, output ready);
endinterface

interface a2a_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [a2a_pkg::ANGLE_WIDTH-1:0] angle;
   modport source (output valid, output angle, input ready);
   modport sink (input valid, input angle, output ready);
endinterface

[src/a2a_div_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2a_div_cell
// One restoring-division cell: shift in a numerator bit, compare, subtract,
// append one quotient bit and hand everything to the next cell.
// ----------------------------------------------------------------------------
module a2a_div_cell #(
   parameter int W  = 31,
   parameter int QW = 31,
   parameter int FW = 30,
   parameter int SW = 6
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          vld_i,
   input  logic [W-1:0]  rem_i,
   input  logic [W-1:0]  div_i,
   input  logic [QW-1:0] quo_i,
   input  logic [FW-1:0] feed_i,
   input  logic [SW-1:0] side_i,
   output logic          vld_o,
   output logic [W-1:0]  rem_o,
   output logic [W-1:0]  div_o,
   output logic [QW-1:0] quo_o,
   output logic [FW-1:0] feed_o,
   output logic [SW-1:0] side_o
);

   logic [W:0]    trial;
   logic          ge;
   logic [W-1:0]  rem_in;
   logic          vld_ff;
   logic [W-1:0]  rem_ff, div_ff;
   logic [QW-1:0] quo_ff;
   logic [FW-1:0] feed_ff;
   logic [SW-1:0] side_ff;

   always_comb begin
      trial  = {rem_i, feed_i[FW-1]};
      ge     = trial >= {1'b0, div_i};
      rem_in = ge ? W'(trial - {1'b0, div_i}) : W'(trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= vld_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         div_ff  <= div_i;
         quo_ff  <= {quo_i[QW-2:0], ge};
         feed_ff <= feed_i << 1;
         side_ff <= side_i;
      end
   end

   assign vld_o  = vld_ff;
   assign rem_o  = rem_ff;
   assign div_o  = div_ff;
   assign quo_o  = quo_ff;
   assign feed_o = feed_ff;
   assign side_o = side_ff;

endmodule

[src/a2a_poly.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2a_poly
// Three multiply stages: polynomial results and the rational denominator.
// ----------------------------------------------------------------------------
module a2a_poly #(
   parameter int SW = 6
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic [a2a_pkg::MODE_WIDTH-1:0]   mode,
   input  logic                             vld_i,
   input  logic [30:0]                      x_i,
   input  logic [SW-1:0]                    side_i,
   output logic                             vld_o,
   output logic [30:0]                      x_o,
   output logic [30:0]                      den_o,
   output logic [30:0]                      fpoly_o,
   output logic [SW-1:0]                    side_o
);

   logic [2:0]    vld_ff;
   logic [SW-1:0] side1_ff, side2_ff, side3_ff;
   logic [31:0]   x1_ff, x2_ff, t1_ff, pq1_ff, pc1_ff, m1_ff;
   logic [31:0]   x2s_ff, pq2_ff, pc2_ff, rp_ff, qd_ff, xx2_ff, mx_ff;
   logic [30:0]   x3_ff, den_ff, f_ff;
   logic [31:0]   cub, f_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], vld_i};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff <= side_i;
         x1_ff    <= 32'(x_i);
         x2_ff    <= a2a_pkg::qmul(32'(x_i), 32'(x_i));
         t1_ff    <= a2a_pkg::qmul(32'(x_i), a2a_pkg::ONE_Q30 - 32'(x_i));
         pq1_ff   <= a2a_pkg::qmul(a2a_pkg::QUARTER_PI_Q30, 32'(x_i));
         pc1_ff   <= a2a_pkg::qmul(a2a_pkg::QUARTER_PI_Q30 + a2a_pkg::K_CUB1, 32'(x_i));
         m1_ff    <= a2a_pkg::qmul(a2a_pkg::K_MIX1, 32'(x_i));

         side2_ff <= side1_ff;
         x2s_ff   <= x1_ff;
         pq2_ff   <= pq1_ff;
         pc2_ff   <= pc1_ff;
         rp_ff    <= a2a_pkg::qmul((mode == a2a_pkg::MODE_RAT1) ?
                                   a2a_pkg::K_RAT1 : a2a_pkg::K_RAT0, x2_ff);
         qd_ff    <= a2a_pkg::qmul((mode == a2a_pkg::MODE_QUAD1) ?
                                   a2a_pkg::K_QUAD1 : a2a_pkg::K_QUAD0, t1_ff);
         xx2_ff   <= a2a_pkg::qmul(x1_ff, x2_ff);
         mx_ff    <= a2a_pkg::qmul(t1_ff, a2a_pkg::K_MIX0 + m1_ff);

         side3_ff <= side2_ff;
         x3_ff    <= x2s_ff[30:0];
         den_ff   <= 31'(a2a_pkg::ONE_Q30 + rp_ff);
         f_ff     <= f_in[30:0];
      end
   end

   always_comb begin
      cub = a2a_pkg::qmul(a2a_pkg::K_CUB3, xx2_ff);
      unique case (mode)
         a2a_pkg::MODE_QUAD0, a2a_pkg::MODE_QUAD1: f_in = pq2_ff + qd_ff;
         a2a_pkg::MODE_CUB:                        f_in = pc2_ff - cub;
         a2a_pkg::MODE_MIX:                        f_in = pq2_ff + mx_ff;
         default:                                  f_in = '0;
      endcase
   end

   assign vld_o   = vld_ff[2];
   assign x_o     = x3_ff;
   assign den_o   = den_ff;
   assign fpoly_o = f_ff;
   assign side_o  = side3_ff;

endmodule

[src/atan2_approx_selectable.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atan2_approx_selectable
// Four-quadrant arctangent of an I/Q pair with six selectable approximations.
// ----------------------------------------------------------------------------
// Takes one item per clock while the result side takes items and returns
// atan2(quadrature, in_phase) in radians with ANGLE_FRAC_BITS fraction bits through
// one input stage, a chain of 30 division cells for the min/max ratio, three
// multiply stages, a second chain of 30 division cells for the rational
// forms, two folding and rounding stages and the output register. The two
// division cell chains set the latency; throughput is one item per cycle
// whenever the result side takes items. Write mode only while no item is in
// flight; codes 6 and 7 act as code 0.
module atan2_approx_selectable #(
   parameter int SAMPLE_WIDTH    = a2a_pkg::DEF_SAMPLE_WIDTH,
   parameter int ANGLE_FRAC_BITS = a2a_pkg::DEF_ANGLE_FRAC_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   a2a_req_if.sink                          req_chan,
   a2a_rsp_if.source                        rsp_chan,
   input  logic                             csr_we,
   input  logic [a2a_pkg::MODE_WIDTH-1:0]   csr_wdata
);

   localparam int MW    = SAMPLE_WIDTH - 1;
   localparam int NC    = a2a_pkg::FRAC_BITS;
   localparam int SIDEW = $bits(a2a_pkg::side_type);
   localparam int SHIFT = a2a_pkg::FRAC_BITS - ANGLE_FRAC_BITS;
   localparam int S2W   = SIDEW + 31;

   logic [a2a_pkg::MODE_WIDTH-1:0] mode_ff;
   logic en;
   logic skid_vld_ff, main_vld_ff;
   logic signed [a2a_pkg::ANGLE_WIDTH-1:0] main_ff, skid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= a2a_pkg::MODE_RAT0;
      end else if (csr_we) begin
         mode_ff <= csr_wdata;
      end
   end

   assign en             = !skid_vld_ff;
   assign req_chan.ready = en;

   // input stage: magnitudes, octant flags, first quotient bit
   logic [MW-1:0] ai, aq, mn_in, mx_in, rem0_in;
   logic [30:0]   quo0_in;
   a2a_pkg::side_type side0_in;
   logic          vld0_ff;
   logic [MW-1:0] rem0_ff, div0_ff;
   logic [30:0]   quo0_ff;
   logic [SIDEW-1:0] side0_ff;

   always_comb begin
      ai = (req_chan.in_phase == {1'b1, {MW{1'b0}}}) ? {MW{1'b1}} :
           (req_chan.in_phase[MW] ? MW'(-req_chan.in_phase) : MW'(req_chan.in_phase));
      aq = (req_chan.quadrature == {1'b1, {MW{1'b0}}}) ? {MW{1'b1}} :
           (req_chan.quadrature[MW] ? MW'(-req_chan.quadrature) : MW'(req_chan.quadrature));
      side0_in.zero     = (ai == '0) && (aq == '0);
      side0_in.swap     = !(ai > aq);
      side0_in.xneg     = req_chan.in_phase[MW] != req_chan.quadrature[MW];
      side0_in.i_pos    = !req_chan.in_phase[MW] && (req_chan.in_phase != '0);
      side0_in.q_nonneg = !req_chan.quadrature[MW];
      side0_in.q_pos    = !req_chan.quadrature[MW] && (req_chan.quadrature != '0);
      mn_in   = side0_in.swap ? ai : aq;
      mx_in   = side0_in.swap ? aq : ai;
      rem0_in = (mn_in == mx_in) ? '0 : mn_in;
      quo0_in = {30'd0, (mn_in == mx_in) && !side0_in.zero};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
      end else if (en) begin
         vld0_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem0_ff  <= rem0_in;
         div0_ff  <= mx_in;
         quo0_ff  <= quo0_in;
         side0_ff <= side0_in;
      end
   end

   // ratio x = min / max in Q30
   logic             d1_vld  [NC+1];
   logic [MW-1:0]    d1_rem  [NC+1];
   logic [MW-1:0]    d1_div  [NC+1];
   logic [30:0]      d1_quo  [NC+1];
   logic [NC-1:0]    d1_feed [NC+1];
   logic [SIDEW-1:0] d1_side [NC+1];

   assign d1_vld[0]  = vld0_ff;
   assign d1_rem[0]  = rem0_ff;
   assign d1_div[0]  = div0_ff;
   assign d1_quo[0]  = quo0_ff;
   assign d1_feed[0] = '0;
   assign d1_side[0] = side0_ff;

   for (genvar k = 0; k < NC; k++) begin : g_ratio
      a2a_div_cell #(.W(MW), .QW(31), .FW(NC), .SW(SIDEW)) u_cell (
         .clock, .reset, .en,
         .vld_i(d1_vld[k]), .rem_i(d1_rem[k]), .div_i(d1_div[k]), .quo_i(d1_quo[k]),
         .feed_i(d1_feed[k]), .side_i(d1_side[k]),
         .vld_o(d1_vld[k+1]), .rem_o(d1_rem[k+1]), .div_o(d1_div[k+1]),
         .quo_o(d1_quo[k+1]), .feed_o(d1_feed[k+1]), .side_o(d1_side[k+1])
      );
   end

   logic             p_vld;
   logic [30:0]      p_x, p_den, p_f;
   logic [SIDEW-1:0] p_side;

   a2a_poly #(.SW(SIDEW)) u_poly (
      .clock, .reset, .en, .mode(mode_ff),
      .vld_i(d1_vld[NC]), .x_i(d1_quo[NC]), .side_i(d1_side[NC]),
      .vld_o(p_vld), .x_o(p_x), .den_o(p_den), .fpoly_o(p_f), .side_o(p_side)
   );

   // rational forms: (x << 30 + den/2) / den
   logic           d2_vld  [NC+1];
   logic [30:0]    d2_rem  [NC+1];
   logic [30:0]    d2_div  [NC+1];
   logic [NC-1:0]  d2_quo  [NC+1];
   logic [NC-1:0]  d2_feed [NC+1];
   logic [S2W-1:0] d2_side [NC+1];

   assign d2_vld[0]  = p_vld;
   assign d2_rem[0]  = p_x;
   assign d2_div[0]  = p_den;
   assign d2_quo[0]  = '0;
   assign d2_feed[0] = p_den[NC:1];
   assign d2_side[0] = {p_side, p_f};

   for (genvar k = 0; k < NC; k++) begin : g_rat
      a2a_div_cell #(.W(31), .QW(NC), .FW(NC), .SW(S2W)) u_cell (
         .clock, .reset, .en,
         .vld_i(d2_vld[k]), .rem_i(d2_rem[k]), .div_i(d2_div[k]), .quo_i(d2_quo[k]),
         .feed_i(d2_feed[k]), .side_i(d2_side[k]),
         .vld_o(d2_vld[k+1]), .rem_o(d2_rem[k+1]), .div_o(d2_div[k+1]),
         .quo_o(d2_quo[k+1]), .feed_o(d2_feed[k+1]), .side_o(d2_side[k+1])
      );
   end

   // octant fold
   a2a_pkg::side_type f_side;
   logic [30:0]        f_mag;
   logic signed [33:0] g, ang_in;
   logic               fv_ff;
   logic signed [33:0] ang_ff;

   always_comb begin
      f_side = a2a_pkg::side_type'(d2_side[NC][S2W-1:31]);
      f_mag  = a2a_pkg::is_rational(mode_ff) ? 31'(d2_quo[NC]) : d2_side[NC][30:0];
      g      = f_side.xneg ? -$signed(34'(f_mag)) : $signed(34'(f_mag));
      if (f_side.zero) begin
         ang_in = '0;
      end else if (!f_side.swap) begin
         if (f_side.i_pos) begin
            ang_in = g;
         end else begin
            ang_in = (f_side.q_nonneg ? $signed(a2a_pkg::PI_Q30) :
                      -$signed(a2a_pkg::PI_Q30)) + g;
         end
      end else begin
         ang_in = (f_side.q_pos ? $signed(a2a_pkg::HALF_PI_Q30) :
                   -$signed(a2a_pkg::HALF_PI_Q30)) - g;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= 1'b0;
      end else if (en) begin
         fv_ff <= d2_vld[NC];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ang_ff <= ang_in;
      end
   end

   // round half away from zero, saturate
   logic [34:0] amag, rmag;
   logic signed [a2a_pkg::ANGLE_WIDTH-1:0] res_in;
   logic        rv_ff;
   logic signed [a2a_pkg::ANGLE_WIDTH-1:0] res_ff;

   always_comb begin
      amag = ang_ff[33] ? 35'(-ang_ff) : 35'(ang_ff);
      rmag = (amag + (35'd1 << (SHIFT - 1))) >> SHIFT;
      if (rmag > a2a_pkg::OUT_MAX) begin
         rmag = a2a_pkg::OUT_MAX;
      end
      res_in = ang_ff[33] ? -$signed(a2a_pkg::ANGLE_WIDTH'(rmag)) :
                            $signed(a2a_pkg::ANGLE_WIDTH'(rmag));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (en) begin
         rv_ff <= fv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   // output register with skid
   logic taking;
   assign taking = main_vld_ff && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (taking) begin
            skid_vld_ff <= 1'b0;
         end
      end else if (rv_ff) begin
         if (main_vld_ff && !taking) begin
            skid_vld_ff <= 1'b1;
         end else begin
            main_vld_ff <= 1'b1;
         end
      end else if (taking) begin
         main_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (taking) begin
            main_ff <= skid_ff;
         end
      end else if (rv_ff) begin
         if (main_vld_ff && !taking) begin
            skid_ff <= res_ff;
         end else begin
            main_ff <= res_ff;
         end
      end
   end

   assign rsp_chan.valid = main_vld_ff;
   assign rsp_chan.angle = main_ff;

endmodule

[src/a2a_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2a_checker
// Port-level checks for the atan2 block, bound to the top level.
// ----------------------------------------------------------------------------
module a2a_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic signed [a2a_pkg::ANGLE_WIDTH-1:0] rsp_angle
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_angle))
      else $error("stalled item changed");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input held off with empty output");

   a_release: assert property (@(posedge clock) disable iff (reset)
      !req_ready && rsp_ready |=> req_ready)
      else $error("skid not drained");

   a_symmetric: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_angle != {1'b1, {(a2a_pkg::ANGLE_WIDTH-1){1'b0}}})
      else $error("angle out of range");

endmodule

bind atan2_approx_selectable a2a_checker u_a2a_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_angle (rsp_chan.angle)
);
